FILE: design/bwm_pkg.sv
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared types and codes of the breakpoint watch matcher: request and result
// records, action and access kind codes, entry flag bits, register indexes.
// ----------------------------------------------------------------------------
package bwm_pkg;

  // fixed field widths
  localparam int ACTION_W  = 3;
  localparam int KIND_W    = 2;
  localparam int SPACE_W   = 3;
  localparam int ADDR_W    = 24;
  localparam int DATA_W    = 8;
  localparam int INDEX_W   = 4;
  localparam int FLAGS_W   = 4;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  // request actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_EVENT     = 3'd0,
    ACT_SET       = 3'd1,
    ACT_CLEAR     = 3'd2,
    ACT_CLEAR_ALL = 3'd3,
    ACT_POLL      = 3'd4
  } action_t;

  // access kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_EXEC  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  // entry flag bit positions
  localparam int FLG_READ  = 0;
  localparam int FLG_WRITE = 1;
  localparam int FLG_EXEC  = 2;
  localparam int FLG_VALUE = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 1'd1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KIND_W-1:0]   event_kind;
    logic [SPACE_W-1:0]  space;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   data_value;
    logic [INDEX_W-1:0]  entry_index;
    logic [FLAGS_W-1:0]  entry_flags;
  } req_t;

  typedef struct packed {
    logic               matched_now;
    logic               pending_hit;
    logic [INDEX_W-1:0] last_hit_index;
    logic [COUNT_W-1:0] selected_hit_count;
  } rsp_t;

  // table operation strobes for the current request
  typedef struct packed {
    logic do_event;
    logic do_set;
    logic do_clear;
    logic do_clear_all;
  } tbl_cmd_t;

  // table outcome, state after the request
  typedef struct packed {
    logic               match_any;
    logic [INDEX_W-1:0] last_idx;
    logic [COUNT_W-1:0] sel_count;
  } tbl_res_t;

endpackage

FILE: design/bwm_stream_if.sv
// ----------------------------------------------------------------------------
// bwm_stream_if
// Valid/ready channel carrying one payload record per request.
// ----------------------------------------------------------------------------
interface bwm_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: design/bwm_table.sv
// ----------------------------------------------------------------------------
// bwm_table
// Watch entry table with per-entry hit counters; compares an access against
// all entries in parallel and applies set, clear and clear-all updates.
// ----------------------------------------------------------------------------
module bwm_table #(
  parameter int NUM_ENTRIES = 16,
  parameter int ADDR_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bwm_pkg::tbl_cmd_t cmd,
  input  bwm_pkg::req_t     req,
  output bwm_pkg::tbl_res_t res
);

  // entry storage
  logic [NUM_ENTRIES-1:0]                       valid_r;
  logic [NUM_ENTRIES-1:0][ADDR_BITS-1:0]        addr_r;
  logic [NUM_ENTRIES-1:0][bwm_pkg::DATA_W-1:0]  value_r;
  logic [NUM_ENTRIES-1:0][bwm_pkg::SPACE_W-1:0] space_r;
  logic [NUM_ENTRIES-1:0][bwm_pkg::FLAGS_W-1:0] flags_r;
  logic [NUM_ENTRIES-1:0][bwm_pkg::COUNT_W-1:0] hits_r;
  logic [NUM_ENTRIES-1:0][bwm_pkg::COUNT_W-1:0] hits_nxt;

  logic [NUM_ENTRIES-1:0] hit_vec;
  logic [NUM_ENTRIES-1:0] sel_vec;
  logic [ADDR_BITS-1:0]   ev_addr;
  logic [31:0]            idx_wide;

  assign ev_addr  = ADDR_BITS'(req.address);
  assign idx_wide = 32'(req.entry_index);

  // per-entry compare and index decode
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      logic same_loc;
      logic val_ok;
      same_loc = valid_r[i] && (space_r[i] == req.space) && (addr_r[i] == ev_addr);
      val_ok   = !flags_r[i][bwm_pkg::FLG_VALUE] || (value_r[i] == req.data_value);
      sel_vec[i] = (idx_wide == 32'(i));
      hit_vec[i] = 1'b0;
      if (cmd.do_event && same_loc) begin
        unique case (req.event_kind)
          bwm_pkg::KIND_EXEC:  hit_vec[i] = flags_r[i][bwm_pkg::FLG_EXEC];
          bwm_pkg::KIND_READ:  hit_vec[i] = flags_r[i][bwm_pkg::FLG_READ] && val_ok;
          bwm_pkg::KIND_WRITE: hit_vec[i] = flags_r[i][bwm_pkg::FLG_WRITE] && val_ok;
          default:             hit_vec[i] = 1'b0;
        endcase
      end
    end
  end

  // next hit counters
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (cmd.do_set && sel_vec[i]) begin
        hits_nxt[i] = '0;
      end else if (hit_vec[i]) begin
        hits_nxt[i] = hits_r[i] + 1'b1;
      end else begin
        hits_nxt[i] = hits_r[i];
      end
    end
  end

  // outcome: selected count, highest hit index
  always_comb begin
    res.match_any = |hit_vec;
    res.sel_count = '0;
    res.last_idx  = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (sel_vec[i]) begin
        res.sel_count = res.sel_count | hits_nxt[i];
      end
      if (hit_vec[i]) begin
        res.last_idx = bwm_pkg::INDEX_W'(i);
      end
    end
  end

  // valid bits and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hits_r  <= '0;
    end else begin
      hits_r <= hits_nxt;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (cmd.do_clear_all) begin
          valid_r[i] <= 1'b0;
        end else if (cmd.do_set && sel_vec[i]) begin
          valid_r[i] <= |req.entry_flags;
        end else if (cmd.do_clear && sel_vec[i]) begin
          valid_r[i] <= 1'b0;
        end
      end
    end
  end

  // entry fields
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (cmd.do_set && sel_vec[i]) begin
        addr_r[i]  <= ev_addr;
        value_r[i] <= req.data_value;
        space_r[i] <= req.space;
        flags_r[i] <= req.entry_flags;
      end
    end
  end

endmodule

FILE: design/breakpoint_watch_matcher_top.sv
// ----------------------------------------------------------------------------
// breakpoint_watch_matcher_top
// Breakpoint/watchpoint matcher with a table of watch entries and hit counters.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request. A request
// is captured in an input register, the table compare and update run in one
// pass behind it, and the result lands in an output register. A new request
// is taken every cycle as long as the result side keeps taking results; a
// request sees every table and flag change made by the request before it. The
// table compare across all entries is the longest path. Configuration writes go
// straight to the two control registers and are meant for an idle block.
module breakpoint_watch_matcher_top #(
  parameter int NUM_ENTRIES = 16,
  parameter int ADDR_BITS   = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bwm_stream_if.sink                      in_ch,
  bwm_stream_if.source                    out_ch,
  input  logic                            cfg_we,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bwm_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  logic                        in_valid_r;
  bwm_pkg::req_t               in_req_r;
  logic                        out_valid_r;
  bwm_pkg::rsp_t               out_rsp_r;
  logic                        enabled_r;
  logic                        active_r;
  logic                        pending_r;
  logic                        pending_nxt;
  logic [bwm_pkg::INDEX_W-1:0] last_hit_r;
  logic [bwm_pkg::INDEX_W-1:0] last_hit_nxt;
  logic                        advance;
  logic                        is_poll;
  bwm_pkg::tbl_cmd_t           cmd;
  bwm_pkg::tbl_res_t           tres;
  bwm_pkg::rsp_t               rsp;

  // handshake
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_rsp_r;

  // request decode
  always_comb begin
    cmd.do_event     = advance && (in_req_r.action == bwm_pkg::ACT_EVENT)
                       && active_r && enabled_r;
    cmd.do_set       = advance && (in_req_r.action == bwm_pkg::ACT_SET);
    cmd.do_clear     = advance && (in_req_r.action == bwm_pkg::ACT_CLEAR);
    cmd.do_clear_all = advance && (in_req_r.action == bwm_pkg::ACT_CLEAR_ALL);
    is_poll          = (in_req_r.action == bwm_pkg::ACT_POLL) && active_r;
  end

  bwm_table #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (in_req_r),
    .res   (tres)
  );

  // sticky pending flag and last hit
  always_comb begin
    pending_nxt  = pending_r;
    last_hit_nxt = last_hit_r;
    if (cmd.do_event && tres.match_any) begin
      pending_nxt  = 1'b1;
      last_hit_nxt = tres.last_idx;
    end else if (advance && is_poll) begin
      pending_nxt = 1'b0;
    end
  end

  // result record
  always_comb begin
    rsp.matched_now        = cmd.do_event && tres.match_any;
    rsp.pending_hit        = is_poll && pending_r;
    rsp.last_hit_index     = last_hit_nxt;
    rsp.selected_hit_count = tres.sel_count;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_req_r <= in_ch.payload;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  // status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      last_hit_r <= '0;
    end else begin
      pending_r  <= pending_nxt;
      last_hit_r <= last_hit_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      active_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bwm_pkg::CFG_ENABLED: enabled_r <= cfg_wdata[0];
        bwm_pkg::CFG_ACTIVE:  active_r  <= cfg_wdata[0];
        default:              ;
      endcase
    end
  end

  // a matching access leaves the pending flag set
  a_match_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_event && tres.match_any) |=> pending_r)
    else $error("pending flag not set after a matching access");

  // an active poll clears the pending flag
  a_poll_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && is_poll) |=> !pending_r)
    else $error("pending flag survived a poll");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  // a result is never both a match and a poll report
  a_match_xor_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rsp_r.matched_now && out_rsp_r.pending_hit))
    else $error("result flags both match and poll");

endmodule

FILE: tb/sv/breakpoint_watch_matcher_top_test.sv
// ----------------------------------------------------------------------------
// breakpoint_watch_matcher_top_test
// Self-checking bench for the breakpoint watch matcher. It drives table set,
// clear and poll requests and access events, keeps its own copy of the watch
// table and flags, and checks every result field against its predicted value.
// Both sides stall at random, and the run walks the enable and debugger
// settings.
// ----------------------------------------------------------------------------
module breakpoint_watch_matcher_top_test;
  import bwm_pkg::*;

  localparam int NUM_ENTRIES   = 16;
  localparam int ADDR_BITS     = 24;
  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_PRINTED   = 40;

  // memory spaces, plus one outside the defined ones
  localparam logic [SPACE_W-1:0] SPACE_MAIN    = 3'd0;
  localparam logic [SPACE_W-1:0] SPACE_AUDIO   = 3'd1;
  localparam logic [SPACE_W-1:0] SPACE_VIDEO   = 3'd2;
  localparam logic [SPACE_W-1:0] SPACE_PALETTE = 3'd4;
  localparam logic [SPACE_W-1:0] SPACE_UNUSED  = 3'd6;

  // codes outside the defined sets
  localparam logic [KIND_W-1:0]   KIND_UNUSED    = 2'd3;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI  = 3'd7;

  // entry flag masks
  localparam logic [FLAGS_W-1:0] MASK_READ  = FLAGS_W'(1 << FLG_READ);
  localparam logic [FLAGS_W-1:0] MASK_WRITE = FLAGS_W'(1 << FLG_WRITE);
  localparam logic [FLAGS_W-1:0] MASK_EXEC  = FLAGS_W'(1 << FLG_EXEC);
  localparam logic [FLAGS_W-1:0] MASK_VALUE = FLAGS_W'(1 << FLG_VALUE);
  localparam logic [FLAGS_W-1:0] MASK_ALL   = '1;

  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;
  localparam logic [DATA_W-1:0] DATA_TOP = '1;

  // watch table model and queue of predicted results
  class watch_scoreboard;
    bit                 enabled = 1'b1;
    bit                 active  = 1'b0;
    bit                 ent_valid [NUM_ENTRIES];
    bit [ADDR_W-1:0]    ent_addr  [NUM_ENTRIES];
    bit [DATA_W-1:0]    ent_value [NUM_ENTRIES];
    bit [SPACE_W-1:0]   ent_space [NUM_ENTRIES];
    bit [FLAGS_W-1:0]   ent_flags [NUM_ENTRIES];
    bit [COUNT_W-1:0]   ent_hits  [NUM_ENTRIES];
    bit                 pending;
    bit [INDEX_W-1:0]   last_hit;
    rsp_t               expected_q [$];
    int                 errors;
    int                 requests;
    int                 results;
    int                 event_hits;
    int                 polled_hits;

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      if (idx == CFG_ENABLED) enabled = val[0];
      else if (idx == CFG_ACTIVE) active = val[0];
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // one entry against one access event
    function bit entry_hit(int e, req_t r);
      if (!ent_valid[e] || ent_space[e] != r.space || ent_addr[e] != r.address) return 1'b0;
      case (r.event_kind)
        KIND_EXEC:  return ent_flags[e][FLG_EXEC];
        KIND_READ:  if (!ent_flags[e][FLG_READ]) return 1'b0;
        KIND_WRITE: if (!ent_flags[e][FLG_WRITE]) return 1'b0;
        default:    return 1'b0;
      endcase
      return !ent_flags[e][FLG_VALUE] || ent_value[e] == r.data_value;
    endfunction

    // apply an accepted request and queue the result it should give
    function void note_request(req_t r);
      rsp_t want;
      int   idx;
      bit   in_table;
      bit   hit;
      bit   polled;
      idx      = int'(r.entry_index);
      in_table = idx < NUM_ENTRIES;
      hit      = 1'b0;
      polled   = 1'b0;
      case (r.action)
        ACT_EVENT: begin
          if (active && enabled) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
              if (entry_hit(e, r)) begin
                ent_hits[e]++;
                hit      = 1'b1;
                last_hit = e[INDEX_W-1:0];
              end
            end
            if (hit) begin
              pending = 1'b1;
              event_hits++;
            end
          end
        end
        ACT_SET: begin
          if (in_table) begin
            ent_addr[idx]  = r.address;
            ent_value[idx] = r.data_value;
            ent_space[idx] = r.space;
            ent_flags[idx] = r.entry_flags;
            ent_hits[idx]  = '0;
            ent_valid[idx] = r.entry_flags != '0;
          end
        end
        ACT_CLEAR: begin
          if (in_table) ent_valid[idx] = 1'b0;
        end
        ACT_CLEAR_ALL: begin
          foreach (ent_valid[e]) ent_valid[e] = 1'b0;
        end
        ACT_POLL: begin
          if (active) begin
            polled      = pending;
            pending     = 1'b0;
            polled_hits += int'(polled);
          end
        end
        default: ;
      endcase
      want.matched_now        = hit;
      want.pending_hit        = polled;
      want.last_hit_index     = last_hit;
      want.selected_hit_count = in_table ? ent_hits[idx] : '0;
      expected_q.push_back(want);
      requests++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
      else if (errors == MAX_PRINTED + 1) $display("further mismatches counted, not shown");
    endtask

    // compare a result with the oldest prediction
    task check_result(rsp_t got);
      rsp_t  want;
      string diffs;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with no request waiting", got));
        return;
      end
      want = expected_q.pop_front();
      results++;
      diffs = "";
      if (got.matched_now !== want.matched_now)
        diffs = {diffs, $sformatf(" matched_now %b/%b", got.matched_now, want.matched_now)};
      if (got.pending_hit !== want.pending_hit)
        diffs = {diffs, $sformatf(" pending_hit %b/%b", got.pending_hit, want.pending_hit)};
      if (got.last_hit_index !== want.last_hit_index)
        diffs = {diffs, $sformatf(" last_hit_index %0d/%0d",
                                  got.last_hit_index, want.last_hit_index)};
      if (got.selected_hit_count !== want.selected_hit_count)
        diffs = {diffs, $sformatf(" selected_hit_count %0d/%0d",
                                  got.selected_hit_count, want.selected_hit_count)};
      if (diffs != "") report($sformatf("result %0d (got/want):%s", results, diffs));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  int                   hold_requests = 0;
  watch_scoreboard      scb = new;

  // pools that make addresses and data repeat, and what each entry was set to
  bit [ADDR_W-1:0]  addr_pool [4];
  bit [DATA_W-1:0]  data_pool [3];
  bit [ADDR_W-1:0]  set_addr  [NUM_ENTRIES];
  bit [DATA_W-1:0]  set_data  [NUM_ENTRIES];
  bit [SPACE_W-1:0] set_space [NUM_ENTRIES];
  bit [FLAGS_W-1:0] set_flags [NUM_ENTRIES];

  bwm_stream_if #(.T(req_t)) req_if ();
  bwm_stream_if #(.T(rsp_t)) res_if ();

  breakpoint_watch_matcher_top #(
    .NUM_ENTRIES(NUM_ENTRIES),
    .ADDR_BITS  (ADDR_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_if),
    .out_ch   (res_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic req_t mk(logic [ACTION_W-1:0] act, logic [KIND_W-1:0] kind,
                              logic [SPACE_W-1:0] sp, logic [ADDR_W-1:0] addr,
                              logic [DATA_W-1:0] data, logic [INDEX_W-1:0] idx,
                              logic [FLAGS_W-1:0] flags);
    req_t r;
    r.action      = act;
    r.event_kind  = kind;
    r.space       = sp;
    r.address     = addr;
    r.data_value  = data;
    r.entry_index = idx;
    r.entry_flags = flags;
    return r;
  endfunction

  // random request: half the events aim at a programmed entry
  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   e;
    if ($urandom_range(0, 99) == 0) addr_pool[2'($urandom_range(2, 3))] = ADDR_W'($urandom());
    if ($urandom_range(0, 99) == 0) data_pool[2] = DATA_W'($urandom());
    r.event_kind  = ($urandom_range(0, 19) == 0) ? KIND_UNUSED
                                                 : KIND_W'($urandom_range(KIND_EXEC, KIND_WRITE));
    r.space       = ($urandom_range(0, 9) == 0) ? SPACE_W'($urandom_range(SPACE_PALETTE + 1, 7))
                                                : SPACE_W'($urandom_range(SPACE_MAIN,
                                                                          SPACE_PALETTE));
    r.address     = ($urandom_range(0, 15) == 0) ? ADDR_W'($urandom())
                                                 : addr_pool[2'($urandom_range(0, 3))];
    r.data_value  = ($urandom_range(0, 15) == 0) ? DATA_W'($urandom())
                                                 : data_pool[2'($urandom_range(0, 2))];
    r.entry_index = INDEX_W'($urandom_range(0, NUM_ENTRIES - 1));
    r.entry_flags = FLAGS_W'($urandom_range(0, MASK_ALL));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.action = ACT_EVENT;
      if ($urandom_range(0, 1)) begin
        e = $urandom_range(0, NUM_ENTRIES - 1);
        r.space   = set_space[e];
        r.address = set_addr[e];
        if (set_flags[e][FLG_EXEC] && $urandom_range(0, 2) == 0) r.event_kind = KIND_EXEC;
        else if (set_flags[e][FLG_READ] && $urandom_range(0, 1)) r.event_kind = KIND_READ;
        else if (set_flags[e][FLG_WRITE]) r.event_kind = KIND_WRITE;
        if (set_flags[e][FLG_VALUE] && $urandom_range(0, 3) != 0) r.data_value = set_data[e];
      end
    end else if (pick < 65) begin
      r.action = ACT_SET;
      set_addr[r.entry_index]  = r.address;
      set_data[r.entry_index]  = r.data_value;
      set_space[r.entry_index] = r.space;
      set_flags[r.entry_index] = r.entry_flags;
    end else if (pick < 72) begin
      r.action = ACT_CLEAR;
    end else if (pick < 74) begin
      r.action = ACT_CLEAR_ALL;
    end else if (pick < 90) begin
      r.action = ACT_POLL;
    end else begin
      r.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end
    return r;
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(req_t r);
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
    scb.note_request(r);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (scb.outstanding() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    scb.write_register(idx, val);
  endtask

  // random requests in bursts with gaps; optional long result stall and pause
  task automatic run_random(int count, bit with_pressure);
    int sent = 0;
    int burst;
    int gap;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < count; b++) begin
        if (with_pressure && sent == count / 4) hold_requests <= hold_requests + 1;
        if (with_pressure && sent == count / 2) wait_until_drained();
        send_request(random_request());
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    wait_until_drained();
  endtask

  // result side: check every result, stall on its own pattern
  initial begin : result_side
    int run_left;
    bit level;
    int hold_left;
    int holds_served;
    res_if.ready = 1'b0;
    run_left     = 0;
    level        = 1'b0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) scb.check_result(res_if.payload);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 3))
            0: begin
              level    = 1'b1;
              run_left = $urandom_range(20, 60);
            end
            1, 2: begin
              level    = 1'b1;
              run_left = $urandom_range(1, 6);
            end
            default: begin
              level    = 1'b0;
              run_left = $urandom_range(1, 5);
            end
          endcase
        end
        run_left--;
        res_if.ready <= level;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             CYCLE_LIMIT, scb.outstanding());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_ENABLED;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    addr_pool[0]   = '0;
    addr_pool[1]   = ADDR_TOP;
    addr_pool[2]   = ADDR_W'($urandom());
    addr_pool[3]   = ADDR_W'($urandom());
    data_pool[0]   = '0;
    data_pool[1]   = DATA_TOP;
    data_pool[2]   = DATA_W'($urandom());
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // debugger closed after reset: events and polls have no effect
    send_request(mk(ACT_SET, KIND_EXEC, SPACE_MAIN, '0, '0, 0, MASK_EXEC));
    send_request(mk(ACT_EVENT, KIND_EXEC, SPACE_MAIN, '0, '0, 0, '0));
    send_request(mk(ACT_POLL, KIND_EXEC, SPACE_MAIN, '0, '0, 0, '0));
    wait_until_drained();
    write_register(CFG_ACTIVE, 1'b1);

    // directed: extremes, every action, value compare, multiple hits
    send_request(mk(ACT_SET, KIND_READ, SPACE_PALETTE, ADDR_TOP, DATA_TOP, 15, MASK_ALL));
    send_request(mk(ACT_SET, KIND_READ, SPACE_VIDEO, 24'h123456, 8'h5a, 1,
                    MASK_READ | MASK_WRITE));
    send_request(mk(ACT_SET, KIND_READ, SPACE_UNUSED, 24'habcdef, 8'h11, 2, '0));
    send_request(mk(ACT_EVENT, KIND_READ, SPACE_PALETTE, ADDR_TOP, DATA_TOP, 15, '0));
    send_request(mk(ACT_EVENT, KIND_WRITE, SPACE_PALETTE, ADDR_TOP, '0, 15, '0));
    send_request(mk(ACT_EVENT, KIND_EXEC, SPACE_PALETTE, ADDR_TOP, '0, 15, '0));
    send_request(mk(ACT_EVENT, KIND_EXEC, SPACE_MAIN, '0, '0, 0, '0));
    send_request(mk(ACT_POLL, KIND_EXEC, SPACE_MAIN, '0, '0, 0, '0));
    send_request(mk(ACT_POLL, KIND_EXEC, SPACE_MAIN, '0, '0, 0, '0));
    send_request(mk(ACT_EVENT, KIND_READ, SPACE_VIDEO, 24'h123456, '0, 1, '0));
    send_request(mk(ACT_EVENT, KIND_UNUSED, SPACE_VIDEO, 24'h123456, 8'h5a, 1, '0));
    send_request(mk(ACT_EVENT, KIND_READ, SPACE_UNUSED, 24'habcdef, 8'h11, 2, '0));
    send_request(mk(ACT_SET, KIND_READ, SPACE_VIDEO, 24'h123456, '0, 3, MASK_WRITE));
    send_request(mk(ACT_EVENT, KIND_WRITE, SPACE_VIDEO, 24'h123456, 8'h77, 3, '0));
    send_request(mk(ACT_CLEAR, KIND_READ, SPACE_AUDIO, '0, '0, 3, '0));
    send_request(mk(ACT_EVENT, KIND_WRITE, SPACE_VIDEO, 24'h123456, 8'h77, 3, '0));
    send_request(mk(ACT_SET, KIND_READ, SPACE_UNUSED, 24'h000100, '0, 4,
                    MASK_EXEC | MASK_VALUE));
    send_request(mk(ACT_EVENT, KIND_EXEC, SPACE_UNUSED, 24'h000100, DATA_TOP, 4, '0));
    send_request(mk(ACT_UNUSED_LO, KIND_EXEC, SPACE_MAIN, '0, '0, 15, '0));
    send_request(mk(ACT_UNUSED_MID, KIND_WRITE, SPACE_AUDIO, ADDR_TOP, DATA_TOP, 1, '0));
    send_request(mk(ACT_UNUSED_HI, KIND_UNUSED, SPACE_UNUSED, ADDR_TOP, DATA_TOP, 4, MASK_ALL));
    send_request(mk(ACT_CLEAR_ALL, KIND_EXEC, SPACE_MAIN, '0, '0, 15, '0));
    send_request(mk(ACT_EVENT, KIND_READ, SPACE_PALETTE, ADDR_TOP, DATA_TOP, 15, '0));
    wait_until_drained();

    // random phases over the enable and debugger settings
    run_random(700, 1'b1);
    write_register(CFG_ENABLED, 1'b0);
    run_random(150, 1'b0);
    write_register(CFG_ENABLED, 1'b1);
    write_register(CFG_ACTIVE, 1'b0);
    run_random(150, 1'b0);
    write_register(CFG_ENABLED, 1'b0);
    run_random(100, 1'b0);
    write_register(CFG_ENABLED, 1'b1);
    write_register(CFG_ACTIVE, 1'b1);
    run_random(500, 1'b1);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (scb.outstanding() != 0)
      scb.report($sformatf("%0d results never arrived", scb.outstanding()));
    $display("run: %0d requests, %0d results checked over five enable/debugger settings",
             scb.requests, scb.results);
    $display("run: %0d events hit the table, %0d polls saw a pending hit, %0d mismatches",
             scb.event_hits, scb.polled_hits, scb.errors);
    if (scb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
